/* sv/rsv_pkg.sv */
// ----------------------------------------------------------------------------
// rsv_pkg: shared types and constants for the span record validator
// Status codes, sequencer states, register indexes and FNV-1a constants.
// ----------------------------------------------------------------------------
`default_nettype none

package rsv_pkg;

    // record geometry
    localparam int RECORD_BYTES = 8;
    localparam int BYTE_IDX_W   = $clog2(RECORD_BYTES);
    localparam int REC_W        = RECORD_BYTES * 8;

    // field widths
    localparam int GLYPH_W  = 16;
    localparam int COUNT8_W = 8;
    localparam int WORD_W   = 16;
    localparam int HASH_W   = 32;
    localparam int STATUS_W = 3;
    localparam int RCNT_W   = 17;

    // FNV-1a 32
    localparam logic [HASH_W-1:0] HASH_BASIS = 32'h811C_9DC5;
    localparam logic [HASH_W-1:0] HASH_PRIME = 32'h0100_0193;

    // four bytes per glyph, applied as a left shift
    localparam int GLYPH_BYTES_SHIFT = 2;

    localparam logic [RCNT_W-1:0] COUNT_MAX = {RCNT_W{1'b1}};

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_GLYPHS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SENTINEL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_HASH   = 2'd2;

    // request types
    localparam logic REQ_RECORD = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_FIELD = 3'd1,
        ST_ORDER     = 3'd2,
        ST_TOO_MANY  = 3'd3,
        ST_MISMATCH  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_WRITE
    } fsm_t;

endpackage

`default_nettype wire

/* sv/rsv_req_if.sv */
// ----------------------------------------------------------------------------
// rsv_req_if: request channel
// valid/ready channel carrying one span record or a finish request.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsv_req_if
    import rsv_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                req_type;
    logic [GLYPH_W-1:0]  first_glyph;
    logic [COUNT8_W-1:0] glyph_count;
    logic [COUNT8_W-1:0] matched_bytes;
    logic [WORD_W-1:0]   first_page_word;
    logic [WORD_W-1:0]   last_page_word;

    modport source (
        output valid, req_type, first_glyph, glyph_count, matched_bytes,
               first_page_word, last_page_word,
        input  ready
    );

    modport sink (
        input  valid, req_type, first_glyph, glyph_count, matched_bytes,
               first_page_word, last_page_word,
        output ready
    );
endinterface

`default_nettype wire

/* sv/rsv_rsp_if.sv */
// ----------------------------------------------------------------------------
// rsv_rsp_if: response channel
// valid/ready channel carrying one verdict per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsv_rsp_if
    import rsv_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                failed;
    logic [HASH_W-1:0]   running_hash;
    logic                stream_done;

    modport source (
        output valid, status, failed, running_hash, stream_done,
        input  ready
    );

    modport sink (
        input  valid, status, failed, running_hash, stream_done,
        output ready
    );
endinterface

`default_nettype wire

/* sv/record_stream_validator_fnv1a.sv */
// ----------------------------------------------------------------------------
// record_stream_validator_fnv1a: span record checker with FNV-1a payload hash
// Checks each 8-byte span record, folds it into a running FNV-1a 32 hash and
// reports a verdict against the expected hash on a finish request.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Handshake          | Payload
//  --------+-----+--------------------+-------------------------------------------
//  req     | in  | valid/ready        | req_type, first_glyph, glyph_count,
//          |     |                    | matched_bytes, first/last_page_word
//  rsp     | out | valid/ready        | status, failed, running_hash, stream_done
//  cfg     | in  | cfg_we, no wait    | cfg_index, cfg_data
//
//  A record transaction runs eight hash steps through the single shared 32x32
//  multiplier (one byte per cycle), then a write-back step. A finish
//  transaction skips the hash steps and goes straight to write-back.
//  req.ready is high only in IDLE; one request is in flight at a time.
//  The response sits in an output register, so a new request is taken while
//  the last response waits; write-back stalls until that register is free.
//  Reset (rst_n low, async) restores stream state, config registers, rsp.valid and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module record_stream_validator_fnv1a
    import rsv_pkg::*;
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_we,
    input  wire [CFG_IDX_W-1:0]   cfg_index,
    input  wire [CFG_DATA_W-1:0]  cfg_data,
    rsv_req_if.sink               req,
    rsv_rsp_if.source             rsp
);

    // ---------------- configuration registers ----------------
    logic [GLYPH_W-1:0] src_glyphs_reg;
    logic [WORD_W-1:0]  sentinel_reg;
    logic [HASH_W-1:0]  exp_hash_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_glyphs_reg <= '0;
            sentinel_reg   <= {WORD_W{1'b1}};
            exp_hash_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SRC_GLYPHS: src_glyphs_reg <= cfg_data[GLYPH_W-1:0];
                CFG_SENTINEL:   sentinel_reg   <= cfg_data[WORD_W-1:0];
                CFG_EXP_HASH:   exp_hash_reg   <= cfg_data[HASH_W-1:0];
                default:        ;   // unused index, write dropped
            endcase
        end
    end

    // ---------------- sequencer ----------------
    fsm_t                  state_reg, state_next;
    logic [BYTE_IDX_W-1:0] byte_idx_reg, byte_idx_next;
    logic                  accept;
    logic                  out_free;
    logic                  do_write;   // write-back cycle commits

    assign accept   = req.valid && req.ready;
    assign out_free = !rsp.valid || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            byte_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            byte_idx_reg <= byte_idx_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        byte_idx_next = byte_idx_reg;
        req.ready     = 1'b0;
        do_write      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req.ready     = 1'b1;
                byte_idx_next = '0;
                if (req.valid)
                begin
                    // finish requests skip the hash loop
                    state_next = (req.req_type == REQ_FINISH) ? S_WRITE : S_HASH;
                end
            end
            S_HASH:
            begin
                byte_idx_next = byte_idx_reg + 1'b1;
                if (byte_idx_reg == BYTE_IDX_W'(RECORD_BYTES - 1))
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (out_free)
                begin
                    do_write   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ---------------- captured request ----------------
    logic                is_finish_reg;
    logic [REC_W-1:0]    rec_reg;   // little-endian byte image of the record

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            is_finish_reg <= req.req_type;
            rec_reg       <= {req.last_page_word, req.first_page_word,
                              req.matched_bytes, req.glyph_count, req.first_glyph};
        end
    end

    logic [GLYPH_W-1:0]  fg;
    logic [COUNT8_W-1:0] gc;
    logic [COUNT8_W-1:0] mb;
    logic [WORD_W-1:0]   fw;
    logic [WORD_W-1:0]   lw;

    assign {lw, fw, mb, gc, fg} = rec_reg;

    // ---------------- stream state ----------------
    logic [HASH_W-1:0]  hash_reg;
    logic               have_prev_reg;
    logic [GLYPH_W-1:0] prev_fg_reg;
    logic [WORD_W-1:0]  prev_fw_reg;
    logic [WORD_W-1:0]  prev_lw_reg;
    logic [RCNT_W-1:0]  rcnt_reg;
    logic               err_seen_reg;
    status_t            first_err_reg;

    // shared hash unit: one byte xor, one 32x32 multiply (low word) per cycle
    logic [7:0]        cur_byte;
    logic [HASH_W-1:0] hash_step;

    assign cur_byte  = rec_reg[{byte_idx_reg, 3'b000} +: 8];
    assign hash_step = (hash_reg ^ {{(HASH_W-8){1'b0}}, cur_byte}) * HASH_PRIME;

    // record checks, evaluated on the held record at write-back
    logic              bad;
    logic              disorder;
    logic              too_many;
    logic [RCNT_W-1:0] rcnt_inc;
    logic [GLYPH_W-1:0] room;
    status_t           rec_status;
    logic              mismatch;
    status_t           fin_status;
    status_t           out_status;
    logic              err_next;

    always_comb
    begin
        room = src_glyphs_reg - fg;   // only meaningful when fg < source count
        bad  = (gc == '0) || (mb == '0)
            || ({2'b00, mb} > {gc, {GLYPH_BYTES_SHIFT{1'b0}}})
            || (fg >= src_glyphs_reg)
            || ({{(GLYPH_W-COUNT8_W){1'b0}}, gc} > room)
            || (fw == sentinel_reg) || (lw == sentinel_reg)
            || (fw > lw);
        disorder = !bad && have_prev_reg
            && ((fg <= prev_fg_reg) || (fw < prev_fw_reg) || (lw < prev_lw_reg));
        rcnt_inc = (rcnt_reg == COUNT_MAX) ? rcnt_reg : rcnt_reg + 1'b1;
        too_many = rcnt_inc > {1'b0, src_glyphs_reg};

        priority if (bad)
            rec_status = ST_BAD_FIELD;
        else if (disorder)
            rec_status = ST_ORDER;
        else if (too_many)
            rec_status = ST_TOO_MANY;
        else
            rec_status = ST_OK;

        mismatch = hash_reg != exp_hash_reg;
        priority if (err_seen_reg)
            fin_status = first_err_reg;
        else if (mismatch)
            fin_status = ST_MISMATCH;
        else
            fin_status = ST_OK;

        out_status = is_finish_reg ? fin_status : rec_status;
        err_next   = err_seen_reg || (rec_status != ST_OK);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= HASH_BASIS;
            have_prev_reg <= 1'b0;
            prev_fg_reg   <= '0;
            prev_fw_reg   <= '0;
            prev_lw_reg   <= '0;
            rcnt_reg      <= '0;
            err_seen_reg  <= 1'b0;
            first_err_reg <= ST_OK;
        end
        else if (state_reg == S_HASH)
        begin
            hash_reg <= hash_step;
        end
        else if (do_write)
        begin
            if (is_finish_reg)
            begin
                // end of stream: back to reset values
                hash_reg      <= HASH_BASIS;
                have_prev_reg <= 1'b0;
                prev_fg_reg   <= '0;
                prev_fw_reg   <= '0;
                prev_lw_reg   <= '0;
                rcnt_reg      <= '0;
                err_seen_reg  <= 1'b0;
                first_err_reg <= ST_OK;
            end
            else
            begin
                rcnt_reg <= rcnt_inc;
                // ordering reference moves only on records that pass field
                // and order checks
                if (!bad && !disorder)
                begin
                    have_prev_reg <= 1'b1;
                    prev_fg_reg   <= fg;
                    prev_fw_reg   <= fw;
                    prev_lw_reg   <= lw;
                end
                if (!err_seen_reg && rec_status != ST_OK)
                begin
                    err_seen_reg  <= 1'b1;
                    first_err_reg <= rec_status;
                end
            end
        end
    end

    // ---------------- output register ----------------
    logic                out_valid_reg;
    status_t             out_status_reg;
    logic                out_failed_reg;
    logic [HASH_W-1:0]   out_hash_reg;
    logic                out_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (do_write)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            out_status_reg <= out_status;
            out_failed_reg <= is_finish_reg ? (err_seen_reg || mismatch) : err_next;
            out_hash_reg   <= hash_reg;
            out_done_reg   <= is_finish_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.failed       = out_failed_reg;
    assign rsp.running_hash = out_hash_reg;
    assign rsp.stream_done  = out_done_reg;

endmodule

`default_nettype wire
